>>> sv/alba_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// alba_pkg
// Shared types, constants and coefficient tables of the audio level analyzer.
// ----------------------------------------------------------------------------
package alba_pkg;

  // Default block length limit
  localparam int unsigned LP_MAX_BLOCK = 4096;

  // Accumulator widths
  localparam int unsigned SQ_W  = 43;
  localparam int unsigned MAG_W = 28;
  localparam int unsigned DIF_W = 29;

  // Iterative unit widths
  localparam int unsigned NUM_W  = 60;
  localparam int unsigned DEN_W  = 25;
  localparam int unsigned REM_W  = 33;
  localparam int unsigned ROOT_W = 30;
  localparam int unsigned STEP_W = 6;

  // Q16.8 values, Q1.16 decay gain and the Q1.15 output full scale
  localparam int unsigned VAL_W = 24;
  localparam logic [VAL_W-1:0] PEAK_RESET = 24'd256000;
  localparam logic [VAL_W-1:0] PEAK_FLOOR = 24'd128000;
  localparam logic [16:0]      DECAY_Q16  = 17'd65470;
  localparam logic [15:0]      ONE_OUT    = 16'd32768;

  // Shared multiplier operand widths
  localparam int unsigned MA_W = 24;
  localparam int unsigned MB_W = 17;
  localparam int unsigned MP_W = MA_W + MB_W;

  typedef enum logic {
    OP_DIV,
    OP_SQRT
  } unit_op_e;

  typedef struct packed {
    logic             start;
    unit_op_e         op;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } unit_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [NUM_W-1:0] res;
  } unit_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ACC,
    ST_DSQ,
    ST_SQRT,
    ST_DMAG,
    ST_DDIF,
    ST_PEAK,
    ST_MUL,
    ST_NDIV,
    ST_SM1,
    ST_SM2,
    ST_OUT
  } state_e;

  // Output channel select: level, bass, treble
  localparam logic [1:0] CH_LEVEL  = 2'd0;
  localparam logic [1:0] CH_BASS   = 2'd1;
  localparam logic [1:0] CH_TREBLE = 2'd2;

  function automatic logic [MB_W-1:0] ch_gain(input logic [1:0] ch);
    logic [MB_W-1:0] g;
    unique case (ch)
      CH_LEVEL:  g = 17'd65536;
      CH_BASS:   g = 17'd91750;
      default:   g = 17'd58982;
    endcase
    return g;
  endfunction

  function automatic logic [MB_W-1:0] ch_coef_old(input logic [1:0] ch);
    logic [MB_W-1:0] c;
    unique case (ch)
      CH_LEVEL:  c = 17'd52429;
      CH_BASS:   c = 17'd55706;
      default:   c = 17'd45875;
    endcase
    return c;
  endfunction

  function automatic logic [MB_W-1:0] ch_coef_new(input logic [1:0] ch);
    logic [MB_W-1:0] c;
    unique case (ch)
      CH_LEVEL:  c = 17'd13107;
      CH_BASS:   c = 17'd9830;
      default:   c = 17'd19661;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

>>> sv/alba_iter_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// alba_iter_unit
// Shared iterative unit: restoring divide, one quotient bit per cycle, or
// integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module alba_iter_unit (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire alba_pkg::unit_req_t req_i,
  output alba_pkg::unit_rsp_t     rsp_o
);
  import alba_pkg::*;

  logic              busy_q, done_q;
  unit_op_e          op_q;
  logic [STEP_W-1:0] cnt_q;
  logic [NUM_W-1:0]  num_q, num_d;
  logic [DEN_W-1:0]  den_q;
  logic [REM_W-1:0]  rem_q, rem_d;
  logic [ROOT_W-1:0] root_q, root_d;

  logic [DEN_W:0]    r_div;
  logic              ge_div;
  logic [REM_W-1:0]  r_sq, trial;
  logic              ge_sq;
  logic              load;

  assign load = req_i.start && !busy_q;

  // One divide or root step
  always_comb begin
    r_div  = {rem_q[DEN_W-1:0], num_q[NUM_W-1]};
    ge_div = r_div >= {1'b0, den_q};
    r_sq   = {rem_q[REM_W-3:0], num_q[NUM_W-1 -: 2]};
    trial  = REM_W'({root_q, 2'b01});
    ge_sq  = r_sq >= trial;
    unique case (op_q)
      OP_DIV: begin
        rem_d  = REM_W'(ge_div ? (r_div - {1'b0, den_q}) : r_div);
        num_d  = {num_q[NUM_W-2:0], ge_div};
        root_d = root_q;
      end
      default: begin
        rem_d  = ge_sq ? (r_sq - trial) : r_sq;
        num_d  = {num_q[NUM_W-3:0], 2'b00};
        root_d = {root_q[ROOT_W-2:0], ge_sq};
      end
    endcase
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (load) begin
        busy_q <= 1'b1;
        cnt_q  <= (req_i.op == OP_DIV) ? STEP_W'(NUM_W - 1) : STEP_W'(ROOT_W - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Advance the datapath
  always_ff @(posedge clk_i) begin
    if (load) begin
      op_q   <= req_i.op;
      num_q  <= req_i.num;
      den_q  <= req_i.den;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      num_q  <= num_d;
      rem_q  <= rem_d;
      root_q <= root_d;
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.res  = (op_q == OP_DIV) ? num_q : NUM_W'(root_q);

endmodule
`default_nettype wire

>>> sv/audio_level_band_analyzer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// audio_level_band_analyzer
// Block RMS / mean / mean-difference meter with peak-tracking gain control.
// ----------------------------------------------------------------------------
// Each sample is accepted, then gets one multiply-accumulate step before the
// next is taken. The sample that closes a block starts the end-of-block
// sequence, which runs on one shared divide/square-root unit at one bit per
// cycle: three 60-step divides, a 30-step root, a peak update and, per
// output, a multiply, a 60-step divide and two smoothing multiplies, then any
// wait for the output register to be taken. Input stall is high all the
// while. The result sits in an output register so the next block can start.
module audio_level_band_analyzer #(
  parameter int unsigned MAX_BLOCK = alba_pkg::LP_MAX_BLOCK
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid,
  output      logic        cfg_ready,
  input  wire logic        cfg_data,
  input  wire logic        in_valid,
  output      logic        in_stall,
  input  wire logic [15:0] sample_i,
  input  wire logic        block_end_i,
  output      logic        out_valid,
  input  wire logic        out_stall,
  output      logic [15:0] level_o,
  output      logic [15:0] bass_o,
  output      logic [15:0] treble_o
);
  import alba_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_BLOCK + 1);

  state_e state_q, state_d;
  logic   enable_q, enable_d;
  logic   kick_q, kick_d;
  logic [1:0] ch_q, ch_d;

  logic [SQ_W-1:0]  sq_q, sq_d;
  logic [MAG_W-1:0] mag_q, mag_d;
  logic [DIF_W-1:0] dif_q, dif_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [15:0]      prev_q, prev_d;
  logic             start_q, start_d;
  logic [VAL_W-1:0] peak_q, peak_d;
  logic [15:0]      sm_q [3];
  logic [15:0]      sm_d [3];
  logic             ov_q, ov_d;

  logic [15:0]      s_q, s_d;
  logic             last_q, last_d;
  logic [VAL_W-1:0] x_q [3];
  logic [VAL_W-1:0] x_d [3];
  logic [MP_W-1:0]  prod_q, prod_d;
  logic [15:0]      nv_q, nv_d;
  logic [15:0]      lv_q, lv_d, bs_q, bs_d, tr_q, tr_d;

  logic [MA_W-1:0]  mul_a;
  logic [MB_W-1:0]  mul_b;
  logic [MP_W-1:0]  prod;

  unit_req_t req;
  unit_rsp_t rsp;

  logic        in_acc, cfg_wr;
  logic [16:0] s_ext, prev_ext, mag17, d17, dmag17;
  logic [SQ_W:0]    sq_sum;
  logic [MAG_W:0]   mag_sum;
  logic [DIF_W:0]   dif_sum;
  logic [VAL_W-1:0] peak_c;
  logic [32:0]      sm_sum;
  logic [CNT_W-1:0] cnt_div;

  alba_iter_unit u_unit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign in_stall  = (state_q != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;

  // Shared multiplier
  assign prod = MP_W'(mul_a) * MP_W'(mul_b);

  // Sample arithmetic
  always_comb begin
    s_ext    = {s_q[15], s_q};
    prev_ext = start_q ? s_ext : {prev_q[15], prev_q};
    mag17    = s_q[15] ? (17'd0 - s_ext) : s_ext;
    d17      = s_ext - prev_ext;
    dmag17   = d17[16] ? (17'd0 - d17) : d17;
    sq_sum   = (SQ_W + 1)'(sq_q) + (SQ_W + 1)'(prod[31:0]);
    mag_sum  = (MAG_W + 1)'(mag_q) + (MAG_W + 1)'(mag17[15:0]);
    dif_sum  = (DIF_W + 1)'(dif_q) + (DIF_W + 1)'(dmag17[15:0]);
    cnt_div  = (cnt_q == '0) ? CNT_W'(1) : cnt_q;
    peak_c   = (x_q[0] > peak_q) ? x_q[0] : prod[VAL_W+15:16];
    sm_sum   = {1'b0, prod_q[31:0]} + {1'b0, prod[31:0]};
  end

  // Sequencer: next state and datapath
  always_comb begin
    state_d  = state_q;
    enable_d = enable_q;
    kick_d   = kick_q;
    ch_d     = ch_q;
    sq_d     = sq_q;
    mag_d    = mag_q;
    dif_d    = dif_q;
    cnt_d    = cnt_q;
    prev_d   = prev_q;
    start_d  = start_q;
    peak_d   = peak_q;
    sm_d     = sm_q;
    ov_d     = ov_q;
    s_d      = s_q;
    last_d   = last_q;
    x_d      = x_q;
    prod_d   = prod_q;
    nv_d     = nv_q;
    lv_d     = lv_q;
    bs_d     = bs_q;
    tr_d     = tr_q;
    mul_a    = '0;
    mul_b    = '0;
    req.start = 1'b0;
    req.op    = OP_DIV;
    req.num   = '0;
    req.den   = DEN_W'(cnt_div);

    // Drop the output item once taken
    if (ov_q && !out_stall) begin
      ov_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && enable_q) begin
          s_d     = sample_i;
          last_d  = block_end_i;
          state_d = ST_ACC;
        end
      end
      ST_ACC: begin
        mul_a   = MA_W'(mag17[15:0]);
        mul_b   = MB_W'(mag17[15:0]);
        start_d = 1'b0;
        if (cnt_q < CNT_W'(MAX_BLOCK)) begin
          sq_d  = sq_sum[SQ_W] ? '1 : sq_sum[SQ_W-1:0];
          mag_d = mag_sum[MAG_W] ? '1 : mag_sum[MAG_W-1:0];
          dif_d = dif_sum[DIF_W] ? '1 : dif_sum[DIF_W-1:0];
          cnt_d = cnt_q + 1'b1;
        end
        prev_d  = s_q;
        state_d = last_q ? ST_DSQ : ST_IDLE;
      end
      ST_DSQ: begin
        req.start = !kick_q;
        req.num   = NUM_W'({sq_q, 16'd0});
        kick_d    = 1'b1;
        if (rsp.done) begin
          kick_d  = 1'b0;
          prod_d  = MP_W'(rsp.res);
          state_d = ST_SQRT;
        end
      end
      ST_SQRT: begin
        req.start = !kick_q;
        req.op    = OP_SQRT;
        req.num   = rsp.res;
        kick_d    = 1'b1;
        if (rsp.done) begin
          kick_d  = 1'b0;
          x_d[0]  = rsp.res[VAL_W-1:0];
          state_d = ST_DMAG;
        end
      end
      ST_DMAG: begin
        req.start = !kick_q;
        req.num   = NUM_W'({mag_q, 8'd0});
        kick_d    = 1'b1;
        if (rsp.done) begin
          kick_d  = 1'b0;
          x_d[1]  = rsp.res[VAL_W-1:0];
          state_d = ST_DDIF;
        end
      end
      ST_DDIF: begin
        req.start = !kick_q;
        req.num   = NUM_W'({dif_q, 8'd0});
        kick_d    = 1'b1;
        if (rsp.done) begin
          kick_d  = 1'b0;
          x_d[2]  = rsp.res[VAL_W-1:0];
          state_d = ST_PEAK;
        end
      end
      ST_PEAK: begin
        mul_a   = peak_q;
        mul_b   = DECAY_Q16;
        peak_d  = (peak_c < PEAK_FLOOR) ? PEAK_FLOOR : peak_c;
        ch_d    = CH_LEVEL;
        state_d = ST_MUL;
      end
      ST_MUL: begin
        mul_a   = x_q[ch_q];
        mul_b   = ch_gain(ch_q);
        prod_d  = prod;
        state_d = ST_NDIV;
      end
      ST_NDIV: begin
        req.start = !kick_q;
        req.num   = NUM_W'(prod_q);
        req.den   = {peak_q, 1'b0};
        kick_d    = 1'b1;
        if (rsp.done) begin
          kick_d  = 1'b0;
          nv_d    = (rsp.res > NUM_W'(ONE_OUT)) ? ONE_OUT : rsp.res[15:0];
          state_d = ST_SM1;
        end
      end
      ST_SM1: begin
        mul_a   = MA_W'(sm_q[ch_q]);
        mul_b   = ch_coef_old(ch_q);
        prod_d  = prod;
        state_d = ST_SM2;
      end
      ST_SM2: begin
        mul_a = MA_W'(nv_q);
        mul_b = ch_coef_new(ch_q);
        sm_d[ch_q] = (nv_q > sm_q[ch_q]) ? nv_q : sm_sum[31:16];
        if (ch_q == CH_TREBLE) begin
          state_d = ST_OUT;
        end else begin
          ch_d    = ch_q + 1'b1;
          state_d = ST_MUL;
        end
      end
      ST_OUT: begin
        if (!ov_q || !out_stall) begin
          lv_d    = sm_q[0];
          bs_d    = sm_q[1];
          tr_d    = sm_q[2];
          ov_d    = 1'b1;
          sq_d    = '0;
          mag_d   = '0;
          dif_d   = '0;
          cnt_d   = '0;
          prev_d  = '0;
          start_d = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // Enable write restarts the meter on a rising enable
    if (cfg_wr) begin
      enable_d = cfg_data;
      if (cfg_data && !enable_q) begin
        sq_d    = '0;
        mag_d   = '0;
        dif_d   = '0;
        cnt_d   = '0;
        prev_d  = '0;
        start_d = 1'b1;
        peak_d  = PEAK_RESET;
        sm_d[0] = '0;
        sm_d[1] = '0;
        sm_d[2] = '0;
      end
    end
  end

  // Control and block state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      enable_q <= 1'b0;
      kick_q   <= 1'b0;
      ch_q     <= CH_LEVEL;
      sq_q     <= '0;
      mag_q    <= '0;
      dif_q    <= '0;
      cnt_q    <= '0;
      prev_q   <= '0;
      start_q  <= 1'b1;
      peak_q   <= PEAK_RESET;
      sm_q[0]  <= '0;
      sm_q[1]  <= '0;
      sm_q[2]  <= '0;
      ov_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      enable_q <= enable_d;
      kick_q   <= kick_d;
      ch_q     <= ch_d;
      sq_q     <= sq_d;
      mag_q    <= mag_d;
      dif_q    <= dif_d;
      cnt_q    <= cnt_d;
      prev_q   <= prev_d;
      start_q  <= start_d;
      peak_q   <= peak_d;
      sm_q     <= sm_d;
      ov_q     <= ov_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    s_q    <= s_d;
    last_q <= last_d;
    x_q    <= x_d;
    prod_q <= prod_d;
    nv_q   <= nv_d;
    lv_q   <= lv_d;
    bs_q   <= bs_d;
    tr_q   <= tr_d;
  end

  assign out_valid = ov_q;
  assign level_o   = lv_q;
  assign bass_o    = bs_q;
  assign treble_o  = tr_q;

endmodule
`default_nettype wire

>>> bench/audio_level_band_analyzer_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// audio_level_band_analyzer_test
// Self-checking bench: blocks of PCM samples go in under random bursts and
// gaps, the output side stalls on its own pattern, and each level/bass/treble
// result is compared with a predictor kept in step with the accepted samples.
// ----------------------------------------------------------------------------
module audio_level_band_analyzer_test;
  import alba_pkg::*;

  localparam int unsigned BLK_LIMIT = LP_MAX_BLOCK;

  typedef struct packed {
    logic [15:0] level;
    logic [15:0] bass;
    logic [15:0] treble;
  } meter_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_data = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [15:0] sample_i = '0;
  logic        block_end_i = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] level_o, bass_o, treble_o;

  audio_level_band_analyzer u_top (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .sample_i(sample_i), .block_end_i(block_end_i),
    .out_valid(out_valid), .out_stall(out_stall),
    .level_o(level_o), .bass_o(bass_o), .treble_o(treble_o)
  );

  // Predictor state
  logic        en_q;
  logic [63:0] sq_acc, mag_acc, dif_acc, peak_q, lvl_q, bas_q, tre_q;
  int          cnt_q;
  int          prev_q;
  logic        first_q;

  meter_t levels_due[$];
  int     mismatches = 0;
  int     hold_cycles = 0;
  bit     stall_random = 1'b1;

  initial forever #4 clk_i = ~clk_i;

  function automatic logic [63:0] root64(input logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic logic [63:0] scale_to_peak(input logic [63:0] x, input logic [63:0] g,
                                                input logic [63:0] pk);
    logic [63:0] q;
    q = (x * g * 64'd32768) / (pk << 16);
    return q > 64'd32768 ? 64'd32768 : q;
  endfunction

  function automatic logic [63:0] ease(input logic [63:0] old, input logic [63:0] nv,
                                       input logic [63:0] a, input logic [63:0] b);
    return nv > old ? nv : (old * a + nv * b) >> 16;
  endfunction

  function automatic void clear_sums();
    sq_acc = 0; mag_acc = 0; dif_acc = 0; cnt_q = 0; prev_q = 0; first_q = 1'b1;
  endfunction

  function automatic void restart_meter();
    clear_sums();
    peak_q = 64'd256000; lvl_q = 0; bas_q = 0; tre_q = 0;
  endfunction

  // Advance the predictor by one accepted sample
  function automatic void predict_sample(input logic [15:0] raw, input logic last);
    int s, p, m, d;
    logic [63:0] c, rms, ma, md, t;
    meter_t r;
    if (!en_q) return;
    s = $signed(raw);
    p = first_q ? s : prev_q;
    first_q = 1'b0;
    if (cnt_q < BLK_LIMIT) begin
      m = s < 0 ? -s : s;
      d = s - p;
      d = d < 0 ? -d : d;
      t = sq_acc + 64'(m) * 64'(m);
      sq_acc = t > ((64'd1 << 43) - 1) ? ((64'd1 << 43) - 1) : t;
      t = mag_acc + 64'(m);
      mag_acc = t > ((64'd1 << 28) - 1) ? ((64'd1 << 28) - 1) : t;
      t = dif_acc + 64'(d);
      dif_acc = t > ((64'd1 << 29) - 1) ? ((64'd1 << 29) - 1) : t;
      cnt_q++;
    end
    prev_q = s;
    if (!last) return;
    c = cnt_q == 0 ? 1 : cnt_q;
    rms = root64((sq_acc << 16) / c);
    ma = (mag_acc << 8) / c;
    md = (dif_acc << 8) / c;
    if (rms > peak_q) peak_q = rms;
    else peak_q = (peak_q * 64'd65470) >> 16;
    if (peak_q < 64'd128000) peak_q = 64'd128000;
    lvl_q = ease(lvl_q, scale_to_peak(rms, 65536, peak_q), 52429, 13107);
    bas_q = ease(bas_q, scale_to_peak(ma, 91750, peak_q), 55706, 9830);
    tre_q = ease(tre_q, scale_to_peak(md, 58982, peak_q), 45875, 19661);
    r.level = lvl_q[15:0]; r.bass = bas_q[15:0]; r.treble = tre_q[15:0];
    levels_due.push_back(r);
    clear_sums();
  endfunction

  // Send one sample, held until accepted
  task automatic send_sample(input logic [15:0] s, input logic last);
    sample_i <= s;
    block_end_i <= last;
    in_valid <= 1'b1;
    do @(posedge clk_i); while (in_stall);
    predict_sample(s, last);
    if ($urandom_range(3) == 0) begin
      in_valid <= 1'b0;
      repeat (1 + $urandom_range(5)) @(posedge clk_i);
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (levels_due.size() != 0) @(posedge clk_i);
    repeat (500) @(posedge clk_i);
  endtask

  task automatic write_enable(input logic v);
    cfg_data <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (v && !en_q) restart_meter();
    en_q = v;
    @(posedge clk_i);
  endtask

  task automatic send_block(input int len, input int mode);
    logic [15:0] s;
    for (int i = 0; i < len; i++) begin
      case (mode)
        0: s = 16'($urandom);
        1: s = i[0] ? 16'h8000 : 16'h7fff;
        2: s = 16'($urandom_range(40)) - 16'd20;
        default: s = 16'($urandom_range(3000)) - 16'd1500;
      endcase
      send_sample(s, i == len - 1);
    end
  endtask

  // Check each result against the oldest expectation
  always @(posedge clk_i) begin
    meter_t e;
    if (rst_ni && out_valid && !out_stall) begin
      if (levels_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h %h %h", level_o, bass_o, treble_o);
      end else begin
        e = levels_due.pop_front();
        if (e.level !== level_o || e.bass !== bass_o || e.treble !== treble_o) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp %0d %0d %0d got %0d %0d %0d",
                     e.level, e.bass, e.treble, level_o, bass_o, treble_o);
        end
      end
    end
  end

  // Receiver stall pattern and long hold-off
  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall <= 1'b1;
    end else if (stall_random) begin
      out_stall <= ($urandom_range(4) == 0);
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic test_disabled();
    en_q = 1'b0;
    restart_meter();
    send_block(5, 0);
    settle();
  endtask

  task automatic test_directed();
    write_enable(1'b1);
    send_sample(16'h8000, 1'b1);
    send_sample(16'h7fff, 1'b1);
    send_sample(16'h0000, 1'b1);
    send_block(4, 1);
    send_block(3, 2);
    send_block(6, 0);
    send_block(2, 3);
    settle();
  endtask

  task automatic test_reenable();
    write_enable(1'b0);
    send_block(3, 0);
    settle();
    write_enable(1'b1);
    write_enable(1'b1);
    send_block(3, 1);
    settle();
  endtask

  task automatic test_long_block();
    send_block(120, 1);
    settle();
  endtask

  task automatic test_backpressure();
    hold_cycles = 3000;
    send_block(2, 0);
    send_block(2, 0);
    send_block(3, 3);
    settle();
  endtask

  task automatic test_random();
    int n, mode, len;
    n = 0;
    while (n < 680) begin
      mode = $urandom_range(3);
      stall_random = ($urandom_range(4) != 0);
      if ($urandom_range(9) == 0) len = 1 + $urandom_range(60);
      else len = 1 + $urandom_range(8);
      send_block(len, mode);
      n += len;
    end
    settle();
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_disabled();
    test_directed();
    test_reenable();
    test_long_block();
    test_backpressure();
    test_random();
    if (mismatches == 0 && levels_due.size() == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

  initial begin
    #20ms;
    $display("FAILED: results differ");
    $finish;
  end
endmodule

>>> filelist.f
sv/alba_pkg.sv
sv/alba_iter_unit.sv
sv/audio_level_band_analyzer.sv
bench/audio_level_band_analyzer_test.sv
